// File: hw/rtl/spgm_pkg.sv
// ----------------------------------------------------------------------------
// spgm_pkg
// Shared types, widths and codes for the stereo pan/gain mixer with meter.
// ----------------------------------------------------------------------------
package spgm_pkg;

    localparam int MAX_BLOCK_FRAMES = 4096;

    localparam int SAMPLE_W   = 24;
    localparam int CNT_W      = $clog2(MAX_BLOCK_FRAMES + 1);
    localparam int DIV_W      = CNT_W + 1;
    localparam int SUM_W      = 60;
    localparam int DIV_STEPS  = SUM_W;
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
        logic signed [SAMPLE_W-1:0] bus_left;
        logic signed [SAMPLE_W-1:0] bus_right;
        logic                       block_end;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_left;
        logic signed [SAMPLE_W-1:0] mixed_right;
        logic        [SAMPLE_W-1:0] meter_peak;
        logic        [SAMPLE_W-1:0] meter_rms;
        logic                       meter_updated;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scale;
        logic mix;
        logic square;
        logic acc;
        logic div_step;
        logic root_init;
        logic root_step;
        logic rms;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic latch;
        logic out_ready;
    } t_stat;

endpackage

// File: hw/rtl/spgm_ctrl.sv
// ----------------------------------------------------------------------------
// spgm_ctrl
// Sequencer: steps one item through the datapath, then the divide and root
// on block-ending frames, then hands the result to the output register.
// ----------------------------------------------------------------------------
module spgm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  spgm_pkg::t_stat i_stat,
    output spgm_pkg::t_cmd  o_cmd
);
    import spgm_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SCALE = 10'b0000000010,
        S_MIX   = 10'b0000000100,
        S_SQ    = 10'b0000001000,
        S_ACC   = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_ROOTI = 10'b0001000000,
        S_ROOT  = 10'b0010000000,
        S_RMS   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = S_SQ;
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_stat.latch) begin
                    n_step  = STEP_W'(DIV_STEPS - 1);
                    n_state = S_DIV;
                end else if (i_stat.out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = S_ROOTI;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_ROOTI: begin
                o_cmd.root_init = 1'b1;
                n_step          = STEP_W'(ROOT_STEPS - 1);
                n_state         = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_step == '0) begin
                    n_state = S_RMS;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_RMS: begin
                o_cmd.rms = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: hw/rtl/spgm_dp.sv
// ----------------------------------------------------------------------------
// spgm_dp
// Datapath: configuration registers, gain, scaling, bus mix, meter
// accumulation, shift-subtract divider, digit-by-digit square root and the
// output register.
// ----------------------------------------------------------------------------
module spgm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spgm_pkg::t_cmd                      i_cmd,
    output spgm_pkg::t_stat                     o_stat,
    input  spgm_pkg::t_in_item                  i_in_data,
    input  logic                                i_cfg_valid,
    input  logic [spgm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [spgm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_cfg_ready,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output spgm_pkg::t_out_item                 o_out_data
);
    import spgm_pkg::*;

    localparam logic        [15:0] UNITY    = 16'd32768;
    localparam logic signed [16:0] PAN_MAX  = 17'sd32768;
    localparam logic signed [16:0] PAN_MIN  = -17'sd32768;
    localparam logic        [55:0] RND_HALF = 56'h2000_0000;
    localparam logic        [25:0] LIM_NEG  = 26'h080_0000;
    localparam logic        [25:0] LIM_POS  = 26'h07F_FFFF;
    localparam logic [SAMPLE_W-1:0] S_MAX   = 24'h7F_FFFF;
    localparam logic [SAMPLE_W-1:0] S_MIN   = 24'h80_0000;

    // configuration
    logic [15:0]        r_volume;
    logic signed [16:0] r_pan;
    logic               r_stereo;

    // gains, recomputed every cycle from the configuration
    logic [15:0]        w_vol_c;
    logic signed [16:0] w_pan_c;
    logic signed [17:0] w_pan_x, w_side_l_s, w_side_r_s;
    logic [31:0]        r_gain_l, r_gain_r;

    // captured item
    logic [SAMPLE_W-1:0] r_mag_l, r_mag_r, r_bus_l, r_bus_r;
    logic                r_neg_l, r_neg_r, r_end;

    logic [55:0]         r_prod_l, r_prod_r;
    logic [SAMPLE_W-1:0] r_abs_l, r_abs_r, r_scl_l, r_scl_r;
    logic [SAMPLE_W-1:0] r_mix_l, r_mix_r;
    logic [47:0]         r_sq_l, r_sq_r;

    // meter state
    logic [CNT_W-1:0]    r_count;
    logic [SAMPLE_W-1:0] r_peak, r_held_peak, r_held_rms;
    logic [SUM_W-1:0]    r_sum;
    logic                r_latch;

    // divider and root
    logic [SUM_W-1:0]    r_quo;
    logic [DIV_W-1:0]    r_rem, r_dsor;
    logic [SUM_W-1:0]    r_rv, r_root, r_rbit;

    logic                r_out_valid;
    t_out_item           r_out;

    // ---------------- gain ----------------
    always_comb begin
        w_vol_c    = (r_volume > UNITY) ? UNITY : r_volume;
        w_pan_c    = (r_pan > PAN_MAX) ? PAN_MAX : ((r_pan < PAN_MIN) ? PAN_MIN : r_pan);
        w_pan_x    = {w_pan_c[16], w_pan_c};
        w_side_l_s = 18'sd32768 - w_pan_x;
        w_side_r_s = 18'sd32768 + w_pan_x;
    end

    always_ff @(posedge i_clk) begin
        r_gain_l <= {16'd0, w_vol_c} * {15'd0, w_side_l_s[16:0]};
        r_gain_r <= {16'd0, w_vol_c} * {15'd0, w_side_r_s[16:0]};
    end

    // ---------------- scaling ----------------
    function automatic logic [SAMPLE_W-1:0] f_limit(input logic [55:0] prod,
                                                    input logic neg);
        logic [55:0] rnd;
        logic [25:0] mag, lim;
        begin
            rnd = prod + RND_HALF;
            mag = rnd[55:30];
            lim = neg ? LIM_NEG : LIM_POS;
            f_limit = (mag > lim) ? lim[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] f_sat_add(input logic [SAMPLE_W-1:0] a,
                                                      input logic [SAMPLE_W-1:0] b);
        logic [SAMPLE_W:0] s;
        begin
            s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
            if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
                f_sat_add = s[SAMPLE_W] ? S_MIN : S_MAX;
            end else begin
                f_sat_add = s[SAMPLE_W-1:0];
            end
        end
    endfunction

    logic [SAMPLE_W-1:0] w_abs_l, w_abs_r, w_pk;
    logic [CNT_W-1:0]    w_n;
    logic [SUM_W:0]      w_acc;
    logic [SUM_W-1:0]    w_sum_sat;

    assign w_abs_l   = f_limit(r_prod_l, r_neg_l);
    assign w_abs_r   = f_limit(r_prod_r, r_neg_r);
    assign w_pk      = (r_abs_l > r_abs_r) ? r_abs_l : r_abs_r;
    assign w_n       = r_count + 1'b1;
    assign w_acc     = {1'b0, r_sum} + (SUM_W+1)'(r_sq_l) + (SUM_W+1)'(r_sq_r);
    assign w_sum_sat = w_acc[SUM_W] ? '1 : w_acc[SUM_W-1:0];

    // divider step
    logic [DIV_W:0]   w_rem_sh, w_rem_sub;
    logic             w_ge;
    // root step
    logic [SUM_W-1:0] w_rt;
    logic             w_rge;

    assign w_rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_dsor};
    assign w_ge      = (w_rem_sh >= {1'b0, r_dsor});
    assign w_rt      = r_root + r_rbit;
    assign w_rge     = (r_rv >= w_rt);

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag_l <= i_in_data.in_left[SAMPLE_W-1]
                     ? SAMPLE_W'(0) - i_in_data.in_left : i_in_data.in_left;
            r_mag_r <= i_in_data.in_right[SAMPLE_W-1]
                     ? SAMPLE_W'(0) - i_in_data.in_right : i_in_data.in_right;
            r_neg_l <= i_in_data.in_left[SAMPLE_W-1];
            r_neg_r <= i_in_data.in_right[SAMPLE_W-1];
            r_bus_l <= i_in_data.bus_left;
            r_bus_r <= i_in_data.bus_right;
            r_end   <= i_in_data.block_end;
        end
        if (i_cmd.scale) begin
            r_prod_l <= 56'(r_mag_l) * 56'(r_gain_l);
            r_prod_r <= 56'(r_mag_r) * 56'(r_gain_r);
        end
        if (i_cmd.mix) begin
            r_abs_l <= w_abs_l;
            r_abs_r <= w_abs_r;
            r_scl_l <= r_neg_l ? SAMPLE_W'(0) - w_abs_l : w_abs_l;
            r_scl_r <= r_neg_r ? SAMPLE_W'(0) - w_abs_r : w_abs_r;
        end
        if (i_cmd.square) begin
            r_sq_l  <= 48'(r_abs_l) * 48'(r_abs_l);
            r_sq_r  <= 48'(r_abs_r) * 48'(r_abs_r);
            r_mix_l <= f_sat_add(r_bus_l, r_scl_l);
            r_mix_r <= r_stereo ? f_sat_add(r_bus_r, r_scl_r) : r_bus_r;
            // the frame that reaches the maximum length closes the block
            r_latch <= r_end || (w_n >= CNT_W'(MAX_BLOCK_FRAMES));
        end
        if (i_cmd.acc && r_latch) begin
            r_quo  <= w_sum_sat;
            r_rem  <= '0;
            r_dsor <= {w_n, 1'b0};
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_rem_sub[DIV_W-1:0] : w_rem_sh[DIV_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
        end
        if (i_cmd.root_init) begin
            r_rv   <= r_quo;
            r_root <= '0;
            r_rbit <= SUM_W'(1) << (SUM_W - 2);
        end
        if (i_cmd.root_step) begin
            if (w_rge) begin
                r_rv   <= r_rv - w_rt;
                r_root <= (r_root >> 1) + r_rbit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_rbit <= r_rbit >> 2;
        end
        if (i_cmd.out_load) begin
            r_out.mixed_left    <= r_mix_l;
            r_out.mixed_right   <= r_mix_r;
            r_out.meter_peak    <= r_held_peak;
            r_out.meter_rms     <= r_held_rms;
            r_out.meter_updated <= r_latch;
        end
    end

    // control and meter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume    <= UNITY;
            r_pan       <= '0;
            r_stereo    <= 1'b1;
            r_count     <= '0;
            r_peak      <= '0;
            r_sum       <= '0;
            r_held_peak <= '0;
            r_held_rms  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_VOLUME: r_volume <= i_cfg_data[15:0];
                    CFG_PAN:    r_pan    <= i_cfg_data;
                    CFG_STEREO: r_stereo <= i_cfg_data[0];
                    default:    ;
                endcase
            end
            if (i_cmd.square && (w_pk > r_peak)) begin
                r_peak <= w_pk;
            end
            if (i_cmd.acc) begin
                if (r_latch) begin
                    r_held_peak <= r_peak;
                    r_peak      <= '0;
                    r_sum       <= '0;
                    r_count     <= '0;
                end else begin
                    r_sum   <= w_sum_sat;
                    r_count <= w_n;
                end
            end
            if (i_cmd.rms) begin
                r_held_rms <= (|r_root[SUM_W-1:SAMPLE_W]) ? '1 : r_root[SAMPLE_W-1:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.latch     = r_latch;
    assign o_stat.out_ready = !r_out_valid || !i_out_stall;
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

endmodule

// File: hw/rtl/stereo_pan_gain_mixer_with_meter_unit.sv
// ----------------------------------------------------------------------------
// stereo_pan_gain_mixer_with_meter_unit
// Scales a stereo frame by volume and linear pan, adds it into the bus with
// saturation (the right side only in stereo mode) and keeps a per-block
// peak and RMS meter. An ordinary frame steps through capture, gain
// multiply, round and saturate, bus mix and square, and accumulate. A frame
// that ends a block (block_end, or the block reaching MAX_BLOCK_FRAMES) also
// runs the one-bit-per-cycle divider (60 steps) and the square root unit
// (30 steps) that produce the RMS value returned with that frame. The output
// register lets the next item enter while a result waits downstream.
// Configuration writes are taken every cycle and must only occur while idle.
// ----------------------------------------------------------------------------
module stereo_pan_gain_mixer_with_meter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  spgm_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output spgm_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [spgm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spgm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import spgm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    spgm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    spgm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: hw/rtl/spgm_checker.sv
// ----------------------------------------------------------------------------
// spgm_checker
// Port-level checks for the mixer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module spgm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input spgm_pkg::t_out_item             o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output item changed while stalled");

    // one item in flight: an accepted item closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after an item was taken");

    // rms of a block never exceeds its peak
    a_rms_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.meter_rms <= o_out_data.meter_peak)
        else $error("meter rms above meter peak");

    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.meter_peak <= 24'd8388608)
        else $error("meter peak out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind stereo_pan_gain_mixer_with_meter_unit spgm_checker u_spgm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
